/* rtl/gwt_pkg.sv */
// Shared constants and types for the granule write tracker
`default_nettype none

package gwt_pkg;

    localparam int MEM_BYTES_DEF     = 65536;
    localparam int GRANULE_BYTES_DEF = 64;
    localparam int QUEUE_DEPTH       = 2;

    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;
    localparam int LEN_W     = 32;
    localparam int KIND_W    = 2;
    localparam int TOUCHED_W = 17;

    typedef enum logic [1:0] {
        OP_REPLY,
        OP_MARK,
        OP_COUNT,
        OP_TOTAL
    } op_t;

    typedef struct packed {
        op_t              op;
        logic             acc;
        logic [BIT_W-1:0] first_bit;
        logic [BIT_W-1:0] last_bit;
        logic [LEN_W-1:0] len;
    } cmd_t;

endpackage

`default_nettype wire

/* rtl/gwt_front.sv */
// Front end: takes a word, classifies it and turns byte bounds into granule bounds
`default_nettype none

module gwt_front #(
    parameter int MEM_BYTES     = gwt_pkg::MEM_BYTES_DEF,
    parameter int GRANULE_BYTES = gwt_pkg::GRANULE_BYTES_DEF,
    localparam int NUM_GRANULES = (MEM_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES,
    localparam int NUM_WORDS    = (NUM_GRANULES + gwt_pkg::WORD_BITS - 1) / gwt_pkg::WORD_BITS,
    localparam int WORD_IDX_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        take,
    input  wire logic                        tracking,
    input  wire logic [gwt_pkg::KIND_W-1:0]  kind,
    input  wire logic [gwt_pkg::LEN_W-1:0]   offset,
    input  wire logic [gwt_pkg::LEN_W-1:0]   length,
    input  wire logic                        q_full,
    output logic                             idle,
    output logic                             q_push,
    output gwt_pkg::cmd_t                    q_cmd,
    output logic [WORD_IDX_W-1:0]            q_first_word,
    output logic [WORD_IDX_W-1:0]            q_last_word
);

    localparam int XW     = $clog2(MEM_BYTES);
    localparam int LOG_G  = $clog2(GRANULE_BYTES);
    localparam int SHIFT  = XW + LOG_G;
    localparam int RW     = XW + 2;
    localparam int PROD_W = XW + RW;
    localparam int SUM_W  = gwt_pkg::LEN_W + 1;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(GRANULE_BYTES) - 64'd1) / 64'(GRANULE_BYTES);
    localparam logic [RW-1:0]    RECIP     = RECIP_FULL[RW-1:0];
    localparam logic [SUM_W-1:0] MEM_LIMIT = SUM_W'(MEM_BYTES);

    localparam logic [gwt_pkg::KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [gwt_pkg::KIND_W-1:0] KIND_RANGE = 2'd1;
    localparam logic [gwt_pkg::KIND_W-1:0] KIND_TOTAL = 2'd2;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CLASS,
        F_DIV,
        F_PUSH
    } fstate_t;

    fstate_t                       state_reg;
    logic [gwt_pkg::KIND_W-1:0]    kind_reg;
    logic [gwt_pkg::LEN_W-1:0]     off_reg;
    logic [gwt_pkg::LEN_W-1:0]     len_reg;
    gwt_pkg::op_t                  op_reg;
    logic                          acc_reg;
    logic [XW-1:0]                 xf_reg;
    logic [XW-1:0]                 xl_reg;
    logic [XW-1:0]                 gf_reg;
    logic [XW-1:0]                 gl_reg;

    logic [SUM_W-1:0]   sum;
    logic [SUM_W-1:0]   end_clip;
    logic [SUM_W-1:0]   end_m1;
    gwt_pkg::op_t       op_next;
    logic               acc_next;
    logic [PROD_W-1:0]  prod_f;
    logic [PROD_W-1:0]  prod_l;
    logic [PROD_W-1:0]  prod_f_sh;
    logic [PROD_W-1:0]  prod_l_sh;
    logic [XW-1:0]      gf_word;
    logic [XW-1:0]      gl_word;

    always_comb
    begin
        sum      = SUM_W'(off_reg) + SUM_W'(len_reg);
        end_clip = (sum > MEM_LIMIT) ? MEM_LIMIT : sum;
        end_m1   = end_clip - SUM_W'(1);
        acc_next = 1'b1;
        op_next  = gwt_pkg::OP_REPLY;
        case (kind_reg)
            KIND_WRITE:
            begin
                acc_next = (sum <= MEM_LIMIT);
                if (acc_next && tracking && (len_reg != '0))
                    op_next = gwt_pkg::OP_MARK;
            end
            KIND_RANGE:
            begin
                if (tracking && (len_reg != '0) && (SUM_W'(off_reg) < MEM_LIMIT))
                    op_next = gwt_pkg::OP_COUNT;
            end
            KIND_TOTAL:
            begin
                if (tracking)
                    op_next = gwt_pkg::OP_TOTAL;
            end
            default:
            begin
                acc_next = 1'b0;
            end
        endcase
    end

    // divide by the granule size through a scaled reciprocal
    assign prod_f    = PROD_W'(xf_reg) * PROD_W'(RECIP);
    assign prod_l    = PROD_W'(xl_reg) * PROD_W'(RECIP);
    assign prod_f_sh = prod_f >> SHIFT;
    assign prod_l_sh = prod_l >> SHIFT;

    assign gf_word = gf_reg >> gwt_pkg::BIT_W;
    assign gl_word = gl_reg >> gwt_pkg::BIT_W;

    always_comb
    begin
        q_cmd.op  = op_reg;
        q_cmd.acc = acc_reg;
        q_cmd.len = len_reg;
        if (op_reg == gwt_pkg::OP_TOTAL)
        begin
            q_cmd.first_bit = '0;
            q_cmd.last_bit  = gwt_pkg::BIT_W'(gwt_pkg::WORD_BITS - 1);
            q_first_word    = '0;
            q_last_word     = WORD_IDX_W'(NUM_WORDS - 1);
        end
        else
        begin
            q_cmd.first_bit = gf_reg[gwt_pkg::BIT_W-1:0];
            q_cmd.last_bit  = gl_reg[gwt_pkg::BIT_W-1:0];
            q_first_word    = gf_word[WORD_IDX_W-1:0];
            q_last_word     = gl_word[WORD_IDX_W-1:0];
        end
    end

    assign idle   = (state_reg == F_IDLE);
    assign q_push = (state_reg == F_PUSH) && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            kind_reg  <= '0;
            off_reg   <= '0;
            len_reg   <= '0;
            op_reg    <= gwt_pkg::OP_REPLY;
            acc_reg   <= 1'b0;
            xf_reg    <= '0;
            xl_reg    <= '0;
            gf_reg    <= '0;
            gl_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (take)
                    begin
                        kind_reg  <= kind;
                        off_reg   <= offset;
                        len_reg   <= length;
                        state_reg <= F_CLASS;
                    end
                end
                F_CLASS:
                begin
                    op_reg    <= op_next;
                    acc_reg   <= acc_next;
                    xf_reg    <= off_reg[XW-1:0];
                    xl_reg    <= end_m1[XW-1:0];
                    state_reg <= F_DIV;
                end
                F_DIV:
                begin
                    gf_reg    <= prod_f_sh[XW-1:0];
                    gl_reg    <= prod_l_sh[XW-1:0];
                    state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!q_full)
                        state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/gwt_queue.sv */
// Short command queue between the front end and the bitmap engine
`default_nettype none

module gwt_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = gwt_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      pop_data,
    output logic                   full,
    output logic                   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    logic do_push;
    logic do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

/* rtl/gwt_back.sv */
// Bitmap engine: clears, marks and counts granule bits one memory word per cycle
`default_nettype none

module gwt_back #(
    parameter int MEM_BYTES     = gwt_pkg::MEM_BYTES_DEF,
    parameter int GRANULE_BYTES = gwt_pkg::GRANULE_BYTES_DEF,
    localparam int NUM_GRANULES = (MEM_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES,
    localparam int NUM_WORDS    = (NUM_GRANULES + gwt_pkg::WORD_BITS - 1) / gwt_pkg::WORD_BITS,
    localparam int WORD_IDX_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           clear_req,
    input  wire logic                           q_empty,
    input  wire gwt_pkg::cmd_t                  q_cmd,
    input  wire logic [WORD_IDX_W-1:0]          q_first_word,
    input  wire logic [WORD_IDX_W-1:0]          q_last_word,
    output logic                                q_pop,
    output logic                                clearing,
    output logic                                done,
    output logic                                accepted,
    output logic [gwt_pkg::TOUCHED_W-1:0]       touched_bytes
);

    localparam int WB    = gwt_pkg::WORD_BITS;
    localparam int PC_W  = $clog2(WB + 1);
    localparam int CNT_W = $clog2(NUM_GRANULES + 1);
    localparam int GB_W  = $clog2(GRANULE_BYTES + 1);
    localparam int PRW   = CNT_W + GB_W;
    localparam int CMP_W = (PRW > gwt_pkg::LEN_W + 1) ? PRW : gwt_pkg::LEN_W + 1;
    localparam logic [WB-1:0] ONES = '1;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_WALK,
        B_TAIL,
        B_SCALE,
        B_REPLY
    } bstate_t;

    function automatic logic [PC_W-1:0] popcount(input logic [WB-1:0] w);
        logic [PC_W-1:0] n;
        n = '0;
        for (int i = 0; i < WB; i++)
            n = n + PC_W'(w[i]);
        return n;
    endfunction

    logic [WB-1:0] bitmap_mem [NUM_WORDS];
    logic [WB-1:0] rd_data_reg;

    bstate_t                          state_reg;
    gwt_pkg::op_t                     op_reg;
    logic                             acc_reg;
    logic [gwt_pkg::BIT_W-1:0]        first_bit_reg;
    logic [gwt_pkg::BIT_W-1:0]        last_bit_reg;
    logic [gwt_pkg::LEN_W-1:0]        len_reg;
    logic [WORD_IDX_W-1:0]            first_word_reg;
    logic [WORD_IDX_W-1:0]            last_word_reg;
    logic [WORD_IDX_W-1:0]            cur_reg;
    logic [WORD_IDX_W-1:0]            clr_reg;
    logic [WB-1:0]                    masked_reg;
    logic                             masked_vld_reg;
    logic [CNT_W-1:0]                 cnt_reg;
    logic [PRW-1:0]                   prod_reg;
    logic                             done_reg;
    logic                             accepted_reg;
    logic [gwt_pkg::TOUCHED_W-1:0]    touched_reg;

    logic [WB-1:0]                    lo_mask;
    logic [WB-1:0]                    hi_mask;
    logic [WB-1:0]                    span_mask;
    logic                             at_last;
    logic [WORD_IDX_W-1:0]            cur_inc;
    logic [WORD_IDX_W-1:0]            rd_addr;
    logic                             mem_we;
    logic [WORD_IDX_W-1:0]            mem_waddr;
    logic [WB-1:0]                    mem_wdata;
    logic [CNT_W-1:0]                 cnt_next;
    logic [CMP_W-1:0]                 prod_ext;
    logic [CMP_W-1:0]                 len_ext;
    logic [CMP_W-1:0]                 mem_ext;
    logic [CMP_W-1:0]                 capped;

    assign lo_mask   = (cur_reg == first_word_reg) ? (ONES << first_bit_reg) : ONES;
    assign hi_mask   = (cur_reg == last_word_reg)
                     ? (ONES >> (gwt_pkg::BIT_W'(WB - 1) - last_bit_reg)) : ONES;
    assign span_mask = lo_mask & hi_mask;
    assign at_last   = (cur_reg == last_word_reg);
    assign cur_inc   = cur_reg + WORD_IDX_W'(1);
    assign cnt_next  = masked_vld_reg ? cnt_reg + CNT_W'(popcount(masked_reg)) : cnt_reg;

    always_comb
    begin
        rd_addr   = cur_reg;
        mem_we    = 1'b0;
        mem_waddr = cur_reg;
        mem_wdata = rd_data_reg | span_mask;
        case (state_reg)
            B_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
            end
            B_IDLE:
            begin
                rd_addr = q_first_word;
            end
            B_WALK:
            begin
                rd_addr = at_last ? cur_reg : cur_inc;
                mem_we  = (op_reg == gwt_pkg::OP_MARK);
            end
            default:
            begin
                rd_addr = cur_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            bitmap_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= bitmap_mem[rd_addr];
    end

    always_comb
    begin
        prod_ext = CMP_W'(prod_reg);
        len_ext  = CMP_W'(len_reg);
        mem_ext  = CMP_W'(MEM_BYTES);
        case (op_reg)
            gwt_pkg::OP_COUNT: capped = (prod_ext > len_ext) ? len_ext : prod_ext;
            gwt_pkg::OP_TOTAL: capped = (prod_ext > mem_ext) ? mem_ext : prod_ext;
            default:           capped = '0;
        endcase
    end

    assign q_pop         = (state_reg == B_IDLE) && !q_empty && !clear_req;
    assign clearing      = (state_reg == B_CLEAR);
    assign done          = done_reg;
    assign accepted      = accepted_reg;
    assign touched_bytes = touched_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_CLEAR;
            op_reg         <= gwt_pkg::OP_REPLY;
            acc_reg        <= 1'b0;
            first_bit_reg  <= '0;
            last_bit_reg   <= '0;
            len_reg        <= '0;
            first_word_reg <= '0;
            last_word_reg  <= '0;
            cur_reg        <= '0;
            clr_reg        <= '0;
            masked_reg     <= '0;
            masked_vld_reg <= 1'b0;
            cnt_reg        <= '0;
            prod_reg       <= '0;
            done_reg       <= 1'b0;
            accepted_reg   <= 1'b0;
            touched_reg    <= '0;
        end
        else
        begin
            done_reg       <= 1'b0;
            masked_vld_reg <= 1'b0;
            masked_reg     <= rd_data_reg & span_mask;
            cnt_reg        <= cnt_next;
            if (clear_req)
            begin
                state_reg <= B_CLEAR;
                clr_reg   <= '0;
            end
            else
            begin
                case (state_reg)
                    B_CLEAR:
                    begin
                        if (clr_reg == WORD_IDX_W'(NUM_WORDS - 1))
                            state_reg <= B_IDLE;
                        else
                            clr_reg <= clr_reg + WORD_IDX_W'(1);
                    end
                    B_IDLE:
                    begin
                        if (!q_empty)
                        begin
                            op_reg         <= q_cmd.op;
                            acc_reg        <= q_cmd.acc;
                            first_bit_reg  <= q_cmd.first_bit;
                            last_bit_reg   <= q_cmd.last_bit;
                            len_reg        <= q_cmd.len;
                            first_word_reg <= q_first_word;
                            last_word_reg  <= q_last_word;
                            cur_reg        <= q_first_word;
                            cnt_reg        <= '0;
                            state_reg      <= (q_cmd.op == gwt_pkg::OP_REPLY) ? B_REPLY : B_WALK;
                        end
                    end
                    B_WALK:
                    begin
                        masked_vld_reg <= (op_reg == gwt_pkg::OP_COUNT) ||
                                          (op_reg == gwt_pkg::OP_TOTAL);
                        if (at_last)
                            state_reg <= B_TAIL;
                        else
                            cur_reg <= cur_inc;
                    end
                    B_TAIL:
                    begin
                        state_reg <= B_SCALE;
                    end
                    B_SCALE:
                    begin
                        prod_reg  <= PRW'(cnt_reg) * PRW'(GRANULE_BYTES);
                        state_reg <= B_REPLY;
                    end
                    B_REPLY:
                    begin
                        done_reg     <= 1'b1;
                        accepted_reg <= acc_reg;
                        touched_reg  <= capped[gwt_pkg::TOUCHED_W-1:0];
                        state_reg    <= B_IDLE;
                    end
                    default:
                    begin
                        state_reg <= B_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/granule_write_tracker.sv */
// Top level of the granule write tracker: config register, front end, queue, bitmap engine
`default_nettype none

// Written-granule tracker for a memory of MEM_BYTES bytes, one bit per granule of
// GRANULE_BYTES bytes, held in a bitmap memory of 64-bit words (16 at the defaults).
// Drive start with kind, offset and length while busy is low to hand in a word; its
// result comes back later as a one-cycle done pulse with accepted and touched_bytes,
// in order, and must be captured in that cycle since there is no back-pressure.
// The front end registers a word, classifies it, divides its bounds by the granule size
// and enqueues it, waiting while the queue is full; a two-entry queue lets it take the
// next word while the bitmap engine works. The engine goes through the bitmap memory one
// word per cycle: a mark, range or total query walks its bitmap words (a total query all
// NUM_WORDS of them, 16 at the defaults) and then the tail, scale and reply states, and a
// word that touches no bitmap word goes straight to reply; the memory's single read and
// write port sets this. After reset and after every write of 1 to the config register
// (cfg_we with cfg_wdata high) the bitmap is cleared one word per cycle, busy held high.
module granule_write_tracker #(
    parameter int MEM_BYTES     = gwt_pkg::MEM_BYTES_DEF,
    parameter int GRANULE_BYTES = gwt_pkg::GRANULE_BYTES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_wdata,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [gwt_pkg::KIND_W-1:0]   kind,
    input  wire logic [gwt_pkg::LEN_W-1:0]    offset,
    input  wire logic [gwt_pkg::LEN_W-1:0]    length,
    output logic                              done,
    output logic                              accepted,
    output logic [gwt_pkg::TOUCHED_W-1:0]     touched_bytes
);

    localparam int NUM_GRANULES = (MEM_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
    localparam int NUM_WORDS    = (NUM_GRANULES + gwt_pkg::WORD_BITS - 1) / gwt_pkg::WORD_BITS;
    localparam int WORD_IDX_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int QDATA_W      = $bits(gwt_pkg::cmd_t) + 2 * WORD_IDX_W;

    logic                   tracking_reg;
    logic                   take;
    logic                   front_idle;
    logic                   clearing;
    logic                   q_push;
    logic                   q_pop;
    logic                   q_full;
    logic                   q_empty;
    gwt_pkg::cmd_t          push_cmd;
    logic [WORD_IDX_W-1:0]  push_first_word;
    logic [WORD_IDX_W-1:0]  push_last_word;
    logic [QDATA_W-1:0]     push_data;
    logic [QDATA_W-1:0]     pop_data;
    gwt_pkg::cmd_t          pop_cmd;
    logic [WORD_IDX_W-1:0]  pop_first_word;
    logic [WORD_IDX_W-1:0]  pop_last_word;

    assign busy = !front_idle || clearing;
    assign take = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tracking_reg <= 1'b0;
        else if (cfg_we)
            tracking_reg <= cfg_wdata;
    end

    gwt_front #(
        .MEM_BYTES     (MEM_BYTES),
        .GRANULE_BYTES (GRANULE_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .tracking     (tracking_reg),
        .kind         (kind),
        .offset       (offset),
        .length       (length),
        .q_full       (q_full),
        .idle         (front_idle),
        .q_push       (q_push),
        .q_cmd        (push_cmd),
        .q_first_word (push_first_word),
        .q_last_word  (push_last_word)
    );

    assign push_data = {push_cmd, push_first_word, push_last_word};

    gwt_queue #(
        .DATA_W (QDATA_W),
        .DEPTH  (gwt_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign {pop_cmd, pop_first_word, pop_last_word} = pop_data;

    gwt_back #(
        .MEM_BYTES     (MEM_BYTES),
        .GRANULE_BYTES (GRANULE_BYTES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .clear_req     (cfg_we && cfg_wdata),
        .q_empty       (q_empty),
        .q_cmd         (pop_cmd),
        .q_first_word  (pop_first_word),
        .q_last_word   (pop_last_word),
        .q_pop         (q_pop),
        .clearing      (clearing),
        .done          (done),
        .accepted      (accepted),
        .touched_bytes (touched_bytes)
    );

`ifndef SYNTH
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> busy)
        else $error("front end took a word but busy did not rise");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !q_pop)
        else $error("command popped while the bitmap is being cleared");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");
`endif

endmodule

`default_nettype wire
